### sv/ipa_pkg.sv
// Package for the index pool allocator: pool geometry, register map,
// mode and status codes, payload and configuration structs.
// No dependencies.
package ipa_pkg;

    // Pool geometry
    localparam int POOL_CAPACITY = 1024;
    localparam int IDX_W         = $clog2(POOL_CAPACITY);
    localparam int CNT_W         = IDX_W + 1;

    // Configuration register map
    localparam int CFG_AW     = 3;
    localparam int CFG_DW     = 32;
    localparam int LOG2_W     = 4;
    localparam logic [LOG2_W-1:0] RESET_LOG2 = 4'd4;
    localparam logic [CNT_W-1:0]  RESET_SIZE_LIMIT = '0;
    localparam logic REG_INIT_LOG2  = 1'b0;
    localparam logic REG_SIZE_LIMIT = 1'b1;

    // Request modes
    localparam logic [1:0] MODE_ALLOC    = 2'd0;
    localparam logic [1:0] MODE_FREE     = 2'd1;
    localparam logic [1:0] MODE_VALIDATE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_REJECTED  = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [IDX_W-1:0] index;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] slot;
        logic             is_allocated;
        logic             grew;
        logic [CNT_W-1:0] current_size;
    } t_out;

    typedef struct packed {
        logic              reinit;
        logic [LOG2_W-1:0] init_log2;
        logic [CNT_W-1:0]  size_limit;
    } t_cfg;

endpackage

### sv/ipa_cfg.sv
// APB-style configuration registers of the index pool allocator.
// Depends on ipa_pkg.
module ipa_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ipa_pkg::CFG_AW-1:0] paddr,
    input  logic [ipa_pkg::CFG_DW-1:0] pwdata,
    output logic [ipa_pkg::CFG_DW-1:0] prdata,
    output logic                       pready,
    output ipa_pkg::t_cfg              o_cfg
);

    logic [ipa_pkg::LOG2_W-1:0] r_init_log2;
    logic [ipa_pkg::CNT_W-1:0]  r_size_limit;
    logic                       r_reinit;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Write registers; flag a pool restart after a write of the initial size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_log2  <= ipa_pkg::RESET_LOG2;
            r_size_limit <= ipa_pkg::RESET_SIZE_LIMIT;
            r_reinit     <= 1'b0;
        end else begin
            r_reinit <= wr_en && (paddr[2] == ipa_pkg::REG_INIT_LOG2);
            if (wr_en) begin
                case (paddr[2])
                    ipa_pkg::REG_INIT_LOG2: r_init_log2 <= pwdata[ipa_pkg::LOG2_W-1:0];
                    default:                r_size_limit <= pwdata[ipa_pkg::CNT_W-1:0];
                endcase
            end
        end
    end

    // Return register contents on read
    always_comb begin
        case (paddr[2])
            ipa_pkg::REG_INIT_LOG2: prdata = ipa_pkg::CFG_DW'(r_init_log2);
            default:                prdata = ipa_pkg::CFG_DW'(r_size_limit);
        endcase
    end

    assign o_cfg.reinit     = r_reinit;
    assign o_cfg.init_log2  = r_init_log2;
    assign o_cfg.size_limit = r_size_limit;

endmodule

### sv/ipa_core.sv
// Allocator core: stack and allocation-map memories, pool state and the
// single-pass request logic between the read stage and the result.
// Depends on ipa_pkg.
module ipa_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ipa_pkg::t_cfg i_cfg,
    input  logic          i_accept,
    input  ipa_pkg::t_in  i_item,
    input  logic          i_advance,
    output logic          o_s1_valid,
    output ipa_pkg::t_out o_result
);

    localparam int IW = ipa_pkg::IDX_W;
    localparam int CW = ipa_pkg::CNT_W;
    localparam logic [CW-1:0] CAP_C  = CW'(ipa_pkg::POOL_CAPACITY);
    localparam logic [CW:0]   CAP_C2 = (CW+1)'(ipa_pkg::POOL_CAPACITY);

    // Active size for a given log2, clamped to the capacity
    function automatic logic [CW-1:0] size_from_log2(input logic [ipa_pkg::LOG2_W-1:0] lg);
        logic [CW-1:0] sz;
        sz = CAP_C;
        if (32'(lg) < IW) begin
            sz = CW'(1) << lg;
        end
        return sz;
    endfunction

    // Memories
    logic [IW-1:0] stack_mem [ipa_pkg::POOL_CAPACITY];
    logic          map_mem   [ipa_pkg::POOL_CAPACITY];

    // Read stage
    logic          r_s1_valid;
    ipa_pkg::t_in  r_s1_item;
    logic [IW-1:0] r_stack_rd;
    logic          r_stack_fwd;
    logic [IW-1:0] r_stack_fwd_data;
    logic          r_map_rd;
    logic          r_map_fwd;
    logic          r_map_fwd_data;

    // Pool state
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_fresh;
    logic [CW-1:0] r_active;
    logic [CW-1:0] n_count;
    logic [CW-1:0] n_fresh;
    logic [CW-1:0] n_active;

    // Request logic
    logic [CW-1:0] c_count;
    logic [CW-1:0] c_fresh;
    logic [CW-1:0] c_active;
    ipa_pkg::t_out res;
    logic [IW-1:0] stack_top;
    logic          map_bit;
    logic          need_grow;
    logic [CW:0]   grow_size;
    logic          grow_fail;
    logic          alloc_ok;
    logic          stack_we_c;
    logic          stack_we;
    logic [IW-1:0] stack_waddr;
    logic [IW-1:0] stack_raddr;
    logic          map_we_c;
    logic          map_we;
    logic [IW-1:0] map_waddr;
    logic          map_wdata;
    logic [CW-1:0] stack_rd_cnt;

    // Merge forwarded writes into the registered read data
    assign stack_top = r_stack_fwd ? r_stack_fwd_data : r_stack_rd;
    // Entries at or above the fresh counter were never set since restart
    assign map_bit   = ({1'b0, r_s1_item.index} < r_fresh) &&
                       (r_map_fwd ? r_map_fwd_data : r_map_rd);

    assign need_grow = r_fresh >= r_active;
    assign grow_size = {1'b0, r_active} << 1;
    assign grow_fail = ((i_cfg.size_limit != '0) && (grow_size > {1'b0, i_cfg.size_limit})) ||
                       (grow_size > CAP_C2);

    // Serve one request
    always_comb begin
        c_count     = r_count;
        c_fresh     = r_fresh;
        c_active    = r_active;
        res         = '0;
        res.status  = ipa_pkg::ST_OK;
        alloc_ok    = 1'b1;
        stack_we_c  = 1'b0;
        stack_waddr = r_count[IW-1:0];
        map_we_c    = 1'b0;
        map_waddr   = r_s1_item.index;
        map_wdata   = 1'b0;
        case (r_s1_item.mode)
            ipa_pkg::MODE_ALLOC: begin
                if ((r_count != '0) && (r_count <= CAP_C)) begin
                    // pop the most recently freed index
                    c_count   = r_count - CW'(1);
                    res.slot  = stack_top;
                    map_we_c  = 1'b1;
                    map_waddr = stack_top;
                    map_wdata = 1'b1;
                end else begin
                    if (need_grow) begin
                        if (grow_fail) begin
                            alloc_ok = 1'b0;
                        end else begin
                            c_active = grow_size[CW-1:0];
                            res.grew = 1'b1;
                        end
                    end
                    if (alloc_ok && (r_fresh < CAP_C)) begin
                        // hand out the next fresh index
                        res.slot  = r_fresh[IW-1:0];
                        c_fresh   = r_fresh + CW'(1);
                        map_we_c  = 1'b1;
                        map_waddr = r_fresh[IW-1:0];
                        map_wdata = 1'b1;
                    end else begin
                        res.status = ipa_pkg::ST_EXHAUSTED;
                        res.slot   = '0;
                        res.grew   = 1'b0;
                    end
                end
            end
            ipa_pkg::MODE_FREE: begin
                if (({1'b0, r_s1_item.index} >= r_active) || !map_bit ||
                    (r_count >= CAP_C)) begin
                    res.status = ipa_pkg::ST_REJECTED;
                end else begin
                    // clear the map bit and push the index
                    map_we_c   = 1'b1;
                    stack_we_c = 1'b1;
                    c_count    = r_count + CW'(1);
                end
            end
            ipa_pkg::MODE_VALIDATE: begin
                res.is_allocated = ({1'b0, r_s1_item.index} < r_active) && map_bit;
            end
            default: begin
            end
        endcase
        res.current_size = c_active;
    end

    // Commit state only when the read stage moves on
    assign stack_we     = i_advance && stack_we_c;
    assign map_we       = i_advance && map_we_c;
    assign n_count      = i_advance ? c_count  : r_count;
    assign n_fresh      = i_advance ? c_fresh  : r_fresh;
    assign n_active     = i_advance ? c_active : r_active;
    assign stack_rd_cnt = n_count - CW'(1);
    assign stack_raddr  = stack_rd_cnt[IW-1:0];

    // Hold pool state; restart it after a write of the initial size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_fresh  <= '0;
            r_active <= size_from_log2(ipa_pkg::RESET_LOG2);
        end else if (i_cfg.reinit) begin
            r_count  <= '0;
            r_fresh  <= '0;
            r_active <= size_from_log2(i_cfg.init_log2);
        end else begin
            r_count  <= n_count;
            r_fresh  <= n_fresh;
            r_active <= n_active;
        end
    end

    // Track the read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_accept) begin
            r_s1_valid <= 1'b1;
        end else if (i_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_item <= i_item;
        end
    end

    // Stack memory: write the pushed index, read the next top with forwarding
    always_ff @(posedge i_clk) begin
        if (stack_we) begin
            stack_mem[stack_waddr] <= r_s1_item.index;
        end
        if (i_accept) begin
            r_stack_rd       <= stack_mem[stack_raddr];
            r_stack_fwd      <= stack_we && (stack_waddr == stack_raddr);
            r_stack_fwd_data <= r_s1_item.index;
        end
    end

    // Allocation map memory: read at the request index with forwarding
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (i_accept) begin
            r_map_rd       <= map_mem[i_item.index];
            r_map_fwd      <= map_we && (map_waddr == i_item.index);
            r_map_fwd_data <= map_wdata;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_result   = res;

    // Fresh indices never pass the active size
    a_fresh_in_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= r_active)
        else $error("fresh counter above active size");

    // Active size stays a power of two
    a_size_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_active))
        else $error("active size not a power of two");

    // Every stacked index was handed out fresh before
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_fresh)
        else $error("stack holds more entries than were handed out");

    // An accepted free pushes exactly one entry
    a_free_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && !i_cfg.reinit && (r_s1_item.mode == ipa_pkg::MODE_FREE) &&
         (res.status == ipa_pkg::ST_OK))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("free did not push the stack");

endmodule

### sv/index_pool_allocator.sv
// Top level of the index pool allocator: configuration port, allocator
// core and result register. Depends on ipa_pkg, ipa_cfg and ipa_core.
//
//  channel   direction  handshake                 payload
//  request   in         i_in_valid / o_in_stall   i_in_data  (ipa_pkg::t_in)
//  result    out        o_out_valid / i_out_stall o_out_data (ipa_pkg::t_out)
//  config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One transaction is accepted per cycle unless o_in_stall is high; its result
// passes the memory read stage, then the request logic into the result register.
// Stack and allocation map are synchronous memories with write forwarding;
// map entries at or above the fresh counter read as free, so reset and a pool
// restart take no clearing pass. A write of the initial size restarts the pool.
// A stalled result holds the read stage, and the request side stalls only
// while both the read stage and the result register are full and the result
// is stalled.
module index_pool_allocator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  ipa_pkg::t_in               i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output ipa_pkg::t_out              o_out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ipa_pkg::CFG_AW-1:0] paddr,
    input  logic [ipa_pkg::CFG_DW-1:0] pwdata,
    output logic [ipa_pkg::CFG_DW-1:0] prdata,
    output logic                       pready
);

    ipa_pkg::t_cfg cfg;
    ipa_pkg::t_out result;
    ipa_pkg::t_out r_out;
    logic          r_out_valid;
    logic          s1_valid;
    logic          advance;
    logic          accept;

    ipa_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ipa_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_accept   (accept),
        .i_item     (i_in_data),
        .i_advance  (advance),
        .o_s1_valid (s1_valid),
        .o_result   (result)
    );

    // Move the read stage on when the result register is free or draining
    assign advance    = s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = s1_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
